// ===== rtl/core/sths_pkg.sv =====
// Shared constants, types and hash/interleave functions for the hash store.
`timescale 1ns / 1ps
package sths_pkg;

  localparam int POOL_ENTRIES  = 4096;
  localparam int MAX_BUCKETS   = 8192;
  localparam int START_BUCKETS = 128;
  localparam int MAX_DIMS      = 8;

  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = PW + 1;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int LW = $clog2(BW + 1);
  localparam int DW = 4;
  localparam int START_LOG = $clog2(START_BUCKETS);

  localparam logic [DW-1:0] DIMS_RESET = DW'(3);
  localparam logic [6:0]    LOAD_RESET = 7'd70;

  localparam logic CFG_NUM_DIMS     = 1'b0;
  localparam logic CFG_LOAD_PERCENT = 1'b1;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_GET = 1'b1;

  // One request as it travels from front to back.
  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [BW-1:0] bucket;
    logic [63:0] wval;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [63:0]   rval;
    logic          hit;
    logic          status;
    logic [CW-1:0] total;
  } rsp_t;

  // Clamp the dimension count to 1..MAX_DIMS.
  function automatic logic [3:0] dims_eff(input logic [DW-1:0] n);
    logic [3:0] r;
    r = n;
    if (n == '0) r = 4'd1;
    if (n > DW'(MAX_DIMS)) r = 4'(MAX_DIMS);
    return r;
  endfunction

  // Morton interleave of the first n coordinates.
  function automatic logic [63:0] interleave(input logic [7:0][31:0] c,
                                             input logic [3:0] n);
    logic [63:0] k;
    logic [6:0]  nb;
    k = '0;
    unique case (n)
      4'd1: nb = 7'd32;
      4'd2: nb = 7'd32;
      4'd3: nb = 7'd21;
      4'd4: nb = 7'd16;
      4'd5: nb = 7'd12;
      4'd6: nb = 7'd10;
      4'd7: nb = 7'd9;
      default: nb = 7'd8;
    endcase
    for (int b = 0; b < 32; b++) begin
      for (int i = 0; i < 8; i++) begin
        if (7'(b) < nb && 4'(i) < n && (b * int'(n) + i) < 64)
          k[b * int'(n) + i] = c[i][b];
      end
    end
    return k;
  endfunction

  // Shift-add-xor hash masked to 2^l buckets.
  function automatic logic [BW-1:0] bucket_of(input logic [63:0] k,
                                              input logic [LW-1:0] l);
    logic [5:0]  sx, sy, sz;
    logic [63:0] h;
    sx = (l >= LW'(8)) ? 6'(l / 8 - 1) : 6'd0;
    sy = (sx >= 6'd1) ? 6'((4 * sx) - 1) : 6'd1;
    sz = 6'(l / 2);
    h = k + (k << sx);
    h = h ^ (h >> sy);
    h = h + (h << sz);
    return BW'(h & ((64'd1 << l) - 64'd1));
  endfunction

endpackage

// ===== rtl/core/sths_front.sv =====
// Front end: accept items, interleave the key into a queue and hash it on the way out.
`timescale 1ns / 1ps
module sths_front import sths_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [7:0][31:0] coords,
  input  logic [63:0]   in_write_value,
  input  logic [DW-1:0] num_dims,
  input  logic [LW-1:0] bucket_log,
  input  logic          q_pop,
  output logic          q_valid,
  output req_t          q_data
);

  // Two-entry queue; a stage register holds the interleaved item before queuing.
  logic         s_vld_r;
  logic         s_op_r;
  logic [63:0]  s_key_r, s_wv_r;
  req_t         q_r [2];
  logic [1:0]   q_cnt_r;
  logic         q_rd_r, q_wr_r;
  logic         enq;

  // Accept only when the item staged plus queued cannot overflow.
  assign in_full = s_vld_r || (q_cnt_r == 2'd2);
  assign enq     = s_vld_r;
  assign q_valid = (q_cnt_r != 2'd0);

  // Hash the oldest entry on its way out, so a growth that finished while it
  // waited is taken into account.
  always_comb begin
    q_data        = q_r[q_rd_r];
    q_data.bucket = bucket_of(q_r[q_rd_r].key, bucket_log);
  end

  // Stage interleaved key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_push && !in_full;
    end
    if (in_push && !in_full) begin
      s_op_r  <= in_opcode;
      s_key_r <= interleave(coords, dims_eff(num_dims));
      s_wv_r  <= in_write_value;
    end
  end

  // Advance the queue pointers and store staged items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_rd_r  <= 1'b0;
      q_wr_r  <= 1'b0;
    end else begin
      if (enq) q_wr_r <= ~q_wr_r;
      if (q_pop && q_valid) q_rd_r <= ~q_rd_r;
      q_cnt_r <= q_cnt_r + 2'(enq) - 2'(q_pop && q_valid);
    end
    if (enq) begin
      q_r[q_wr_r].op     <= s_op_r;
      q_r[q_wr_r].key    <= s_key_r;
      q_r[q_wr_r].wval   <= s_wv_r;
    end
  end

endmodule

// ===== rtl/core/sths_back.sv =====
// Back end: walk bucket chains, update the pool, rebuild after growth.
`timescale 1ns / 1ps
module sths_back import sths_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  req_t          q_data,
  output logic          q_pop,
  input  logic [6:0]    load_percent,
  output logic [LW-1:0] bucket_log,
  output logic          rsp_valid,
  output rsp_t          rsp_data,
  input  logic          rsp_ready
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_HWAIT = 4'd3;
  localparam logic [3:0] S_ENT   = 4'd4;
  localparam logic [3:0] S_EWAIT = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_GROW  = 4'd7;
  localparam logic [3:0] S_RKEY  = 4'd8;
  localparam logic [3:0] S_RKW   = 4'd9;
  localparam logic [3:0] S_RHASH = 4'd10;
  localparam logic [3:0] S_RHD   = 4'd11;
  localparam logic [3:0] S_RLINK = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // Memories. Heads carry a valid flag in the top bit.
  logic [PW:0]   head_mem [MAX_BUCKETS];
  logic [63:0]   key_mem  [POOL_ENTRIES];
  logic [63:0]   val_mem  [POOL_ENTRIES];
  logic [PW:0]   link_mem [POOL_ENTRIES];

  logic [3:0]    st_r;
  logic [BW-1:0] clr_r;
  logic [LW-1:0] blog_r;
  logic [CW-1:0] cnt_r;
  req_t          req_r;
  logic [PW:0]   cur_r;
  logic [CW-1:0] steps_r;
  logic [PW:0]   hd_rd_r, ln_rd_r;
  logic [63:0]   k_rd_r, v_rd_r;
  logic          found_r;
  logic [PW-1:0] slot_r;
  rsp_t          rsp_r;
  logic          rsp_vld_r;
  logic [CW-1:0] re_r;
  logic [BW-1:0] rb_r;
  logic [63:0]   rk_r;

  // Head port
  logic          h_we;
  logic [BW-1:0] h_wa, h_ra;
  logic [PW:0]   h_wd;
  // Entry ports
  logic          k_we, v_we, l_we;
  logic [PW-1:0] e_wa, e_ra;
  logic [63:0]   k_wd, v_wd;
  logic [PW:0]   l_wd;

  logic [BW:0]   buckets;
  logic          grow_ok;

  assign bucket_log = blog_r;
  assign rsp_valid  = rsp_vld_r;
  assign rsp_data   = rsp_r;
  assign q_pop      = (st_r == S_IDLE) && q_valid && !rsp_vld_r;
  assign buckets    = (BW+1)'(1) << blog_r;
  assign grow_ok    = (buckets < (BW+1)'(MAX_BUCKETS)) &&
                      ((32'(cnt_r) * 32'd100) > (32'(load_percent) * 32'(buckets)));

  always_ff @(posedge clk) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    hd_rd_r <= head_mem[h_ra];
  end
  always_ff @(posedge clk) begin
    if (k_we) key_mem[e_wa] <= k_wd;
    k_rd_r <= key_mem[e_ra];
  end
  always_ff @(posedge clk) begin
    if (v_we) val_mem[e_wa] <= v_wd;
    v_rd_r <= val_mem[e_ra];
  end
  always_ff @(posedge clk) begin
    if (l_we) link_mem[e_wa] <= l_wd;
    ln_rd_r <= link_mem[e_ra];
  end

  // Memory port control.
  always_comb begin
    h_we = 1'b0; h_wa = clr_r; h_wd = '0; h_ra = req_r.bucket;
    k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
    e_wa = slot_r; e_ra = cur_r[PW-1:0];
    k_wd = req_r.key; v_wd = req_r.wval; l_wd = hd_rd_r;
    unique case (st_r)
      S_CLR, S_GROW: begin
        h_we = 1'b1;
      end
      S_DONE: begin
        if (req_r.op == OP_SET && found_r) begin
          v_we = 1'b1;
        end else if (req_r.op == OP_SET && cnt_r < CW'(POOL_ENTRIES)) begin
          e_wa = cnt_r[PW-1:0];
          k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
          h_we = 1'b1; h_wa = req_r.bucket; h_wd = {1'b1, cnt_r[PW-1:0]};
        end
      end
      S_RKEY: e_ra = re_r[PW-1:0];
      S_RHD:  h_ra = rb_r;
      S_RHASH: h_ra = rb_r;
      S_RLINK: begin
        e_wa = re_r[PW-1:0]; l_we = 1'b1; l_wd = hd_rd_r;
        h_we = 1'b1; h_wa = rb_r; h_wd = {1'b1, re_r[PW-1:0]};
      end
      default: ;
    endcase
  end

  // Sequencer: clear, look up head, walk chain, apply, optionally rebuild.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLR;
      clr_r     <= '0;
      blog_r    <= LW'(START_LOG);
      cnt_r     <= '0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (rsp_vld_r && rsp_ready) rsp_vld_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(MAX_BUCKETS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            req_r   <= q_data;
            found_r <= 1'b0;
            steps_r <= '0;
            st_r    <= S_HEAD;
          end
        end
        S_HEAD: st_r <= S_HWAIT;
        S_HWAIT: begin
          cur_r <= hd_rd_r;
          st_r  <= S_ENT;
        end
        S_ENT: begin
          if (cur_r[PW] && CW'(cur_r[PW-1:0]) < cnt_r && steps_r <= cnt_r) st_r <= S_EWAIT;
          else st_r <= S_DONE;
        end
        S_EWAIT: begin
          if (k_rd_r == req_r.key) begin
            found_r <= 1'b1;
            slot_r  <= cur_r[PW-1:0];
            st_r    <= S_DONE;
          end else begin
            cur_r   <= ln_rd_r;
            steps_r <= steps_r + 1'b1;
            st_r    <= S_ENT;
          end
        end
        S_DONE: begin
          rsp_r.hit  <= found_r;
          rsp_r.rval <= (req_r.op == OP_GET && found_r) ? v_rd_r : 64'd0;
          if (req_r.op == OP_GET) begin
            rsp_r.status <= 1'b0;
            rsp_r.total  <= cnt_r;
            rsp_vld_r    <= 1'b1;
            st_r         <= S_IDLE;
          end else if (found_r) begin
            rsp_r.status <= 1'b0;
            rsp_r.total  <= cnt_r;
            st_r         <= S_OUT;
          end else if (cnt_r < CW'(POOL_ENTRIES)) begin
            cnt_r        <= cnt_r + 1'b1;
            rsp_r.status <= 1'b0;
            rsp_r.total  <= cnt_r + 1'b1;
            st_r         <= S_OUT;
          end else begin
            // Pool full: drop the set, skip the growth check.
            rsp_r.status <= 1'b1;
            rsp_r.total  <= cnt_r;
            rsp_vld_r    <= 1'b1;
            st_r         <= S_IDLE;
          end
        end
        S_OUT: begin
          // Growth check after a set.
          rsp_vld_r <= 1'b1;
          if (grow_ok) begin
            blog_r <= blog_r + 1'b1;
            clr_r  <= '0;
            st_r   <= S_GROW;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_GROW: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(MAX_BUCKETS - 1)) begin
            re_r <= '0;
            st_r <= (cnt_r == '0) ? S_IDLE : S_RKEY;
          end
        end
        S_RKEY: st_r <= S_RKW;
        S_RKW: begin
          rk_r <= k_rd_r;
          st_r <= S_RHASH;
        end
        S_RHASH: begin
          rb_r <= bucket_of(rk_r, blog_r);
          st_r <= S_RHD;
        end
        S_RHD: st_r <= S_RLINK;
        S_RLINK: begin
          re_r <= re_r + 1'b1;
          st_r <= (re_r + 1'b1 == cnt_r) ? S_IDLE : S_RKEY;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sparse_tensor_hash_store.sv =====
// Top level of the sparse tensor hash store.
//
//  channel | handshake          | beat
//  in_     | in_push / in_full  | opcode, 8 coords, write_value
//  out_    | out_pop / out_empty| read_value, hit, status, entry_total
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A get or set reads the bucket head, then walks its chain entry by entry until
// a key matches or the chain ends. A set that grows the table adds a sweep that
// clears all MAX_BUCKETS heads, then rehashes and relinks every stored entry.
// After reset the head memory is cleared before the first item is processed.
// Either side may stall; a two-deep queue parts front and back, and the back
// starts no item while a result beat waits.
`timescale 1ns / 1ps
module sparse_tensor_hash_store import sths_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [31:0]   in_coord_0,
  input  logic [31:0]   in_coord_1,
  input  logic [31:0]   in_coord_2,
  input  logic [31:0]   in_coord_3,
  input  logic [31:0]   in_coord_4,
  input  logic [31:0]   in_coord_5,
  input  logic [31:0]   in_coord_6,
  input  logic [31:0]   in_coord_7,
  input  logic [63:0]   in_write_value,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [63:0]   out_read_value,
  output logic          out_hit,
  output logic          out_status,
  output logic [12:0]   out_entry_total,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data
);

  logic [DW-1:0] dims_r;
  logic [6:0]    load_r;
  logic [LW-1:0] blog;
  logic          q_valid, q_pop, rsp_valid;
  req_t          q_data;
  rsp_t          rsp;
  logic [7:0][31:0] coords;

  assign coords = {in_coord_7, in_coord_6, in_coord_5, in_coord_4,
                   in_coord_3, in_coord_2, in_coord_1, in_coord_0};
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
      load_r <= LOAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_DIMS:     dims_r <= cfg_data[DW-1:0];
        CFG_LOAD_PERCENT: load_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sths_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .coords, .in_write_value,
    .num_dims(dims_r), .bucket_log(blog), .q_pop, .q_valid, .q_data
  );

  sths_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop, .load_percent(load_r),
    .bucket_log(blog), .rsp_valid, .rsp_data(rsp), .rsp_ready(out_pop)
  );

  assign out_empty       = !rsp_valid;
  assign out_read_value  = rsp.rval;
  assign out_hit         = rsp.hit;
  assign out_status      = rsp.status;
  assign out_entry_total = rsp.total;

endmodule
